// ===== design/greedy_pattern_replace_stream_top_macros.svh =====
// Assertion macros shared by the greedy pattern replace stream modules.
// Defining ASSERT_OFF removes every check; no other dependencies.
`ifndef GREEDY_PATTERN_REPLACE_STREAM_TOP_MACROS_SVH
`define GREEDY_PATTERN_REPLACE_STREAM_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// A property checked on every rising edge outside reset.
`define GPRS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gprs assertion failed");

// An antecedent that forces a consequent in the same cycle.
`define GPRS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gprs implication failed");

`else

`define GPRS_ASSERT(lbl, clk, rst_n, prop)
`define GPRS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/gprs_pkg.sv =====
// Shared types and constants of the greedy pattern replace stream block.
// No dependencies; used by the controller, the datapath and the top level.
package gprs_pkg;

    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 6;
    localparam int CHAR_W    = 8;
    localparam int PLABEL_W  = 8;
    localparam int STATUS_W  = 2;
    localparam int LEN_W     = 6;
    localparam int LIMIT_W   = 18;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD_PAT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_REP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEXT     = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDEF    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REP_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 18'h20000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic pat_wr;
        logic rep_wr;
        logic win_clear;
        logic win_shift;
        logic win_push;
        logic emit_win;
        logic repl_start;
        logic emit_repl;
        logic emit_end;
        logic end_undef;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] item_cmd;
        logic             item_last;
        logic             plen_zero;
        logic             fill_ge_plen;
        logic             fill_eq_plen;
        logic             fill_zero;
        logic             match;
        logic             repl_go;
        logic             repl_last;
        logic             out_free;
    } t_dp_stat;

endpackage

// ===== design/gprs_dp.sv =====
// Datapath: configuration registers, pattern store, replacement memory,
// match window with parallel compare, output counters and output register.
// Depends on gprs_pkg and the assertion macro header.
`include "greedy_pattern_replace_stream_top_macros.svh"

module gprs_dp #(
    parameter int MAX_PATTERN     = 32,
    parameter int MAX_REPLACEMENT = 48,
    parameter int LABEL_BITS      = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [gprs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gprs_pkg::LIMIT_W-1:0]     i_cfg_data,
    input  logic [gprs_pkg::CMD_W-1:0]       i_cmd,
    input  logic [gprs_pkg::SLOT_W-1:0]      i_slot,
    input  logic [gprs_pkg::CHAR_W-1:0]      i_char_code,
    input  logic signed [gprs_pkg::PLABEL_W-1:0] i_label,
    input  logic                             i_last,
    input  gprs_pkg::t_dp_cmd                i_dp_cmd,
    output gprs_pkg::t_dp_stat               o_dp_stat,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_atom_valid,
    output logic [gprs_pkg::CHAR_W-1:0]      o_out_char,
    output logic signed [gprs_pkg::PLABEL_W-1:0] o_out_label,
    output logic                             o_end_of_text,
    output logic [gprs_pkg::STATUS_W-1:0]    o_status
);
    import gprs_pkg::*;

    localparam int FW  = $clog2(MAX_PATTERN + 1);
    localparam int RA  = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;
    localparam int RCW = $clog2(MAX_REPLACEMENT + 1);
    localparam int EW  = LABEL_BITS + CHAR_W;

    // Configuration registers.
    logic [LEN_W-1:0]   r_pat_len;
    logic [LEN_W-1:0]   r_rep_len;
    logic [LIMIT_W-1:0] r_out_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len   <= '0;
            r_rep_len   <= '0;
            r_out_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PAT_LEN:   r_pat_len   <= i_cfg_data[LEN_W-1:0];
                REG_REP_LEN:   r_rep_len   <= i_cfg_data[LEN_W-1:0];
                REG_OUT_LIMIT: r_out_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [FW-1:0]  plen;
    logic [RCW-1:0] rn;

    assign plen = (32'(r_pat_len) > MAX_PATTERN) ? FW'(MAX_PATTERN) : FW'(r_pat_len);
    assign rn   = (32'(r_rep_len) > MAX_REPLACEMENT) ? RCW'(MAX_REPLACEMENT)
                                                     : RCW'(r_rep_len);

    // Captured input beat.
    logic [CMD_W-1:0]    r_item_cmd;
    logic [SLOT_W-1:0]   r_item_slot;
    logic [CHAR_W-1:0]   r_item_char;
    logic [PLABEL_W-1:0] r_item_label;
    logic                r_item_last;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_item_cmd   <= i_cmd;
            r_item_slot  <= i_slot;
            r_item_char  <= i_char_code;
            r_item_label <= i_label;
            r_item_last  <= i_last;
        end
    end

    // Labels are held internally in LABEL_BITS bits, two's complement.
    logic [LABEL_BITS-1:0] item_label_st;

    for (genvar b = 0; b < LABEL_BITS; b++) begin : g_lbl_in
        if (b < PLABEL_W) begin : g_bit
            assign item_label_st[b] = r_item_label[b];
        end else begin : g_ext
            assign item_label_st[b] = r_item_label[PLABEL_W-1];
        end
    end

    // Pattern store and match window, one register per entry.
    logic [CHAR_W-1:0]     r_pat     [MAX_PATTERN];
    logic [CHAR_W-1:0]     r_win_chr [MAX_PATTERN];
    logic [LABEL_BITS-1:0] r_win_lbl [MAX_PATTERN];
    logic [FW-1:0]         r_fill;
    logic [MAX_PATTERN-1:0] entry_ok;

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_win
        always_ff @(posedge i_clk) begin
            if (i_dp_cmd.pat_wr && (32'(r_item_slot) == g)) begin
                r_pat[g] <= r_item_char;
            end
        end

        if (g < MAX_PATTERN - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_dp_cmd.win_shift) begin
                    r_win_chr[g] <= r_win_chr[g+1];
                    r_win_lbl[g] <= r_win_lbl[g+1];
                end else if (i_dp_cmd.win_push && (r_fill == FW'(g))) begin
                    r_win_chr[g] <= r_item_char;
                    r_win_lbl[g] <= item_label_st;
                end
            end
        end else begin : g_top
            always_ff @(posedge i_clk) begin
                if (i_dp_cmd.win_push && !i_dp_cmd.win_shift && (r_fill == FW'(g))) begin
                    r_win_chr[g] <= r_item_char;
                    r_win_lbl[g] <= item_label_st;
                end
            end
        end

        // Entries past the pattern length take no part in the compare.
        assign entry_ok[g] = (FW'(g) >= plen) || (r_win_chr[g] == r_pat[g]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_dp_cmd.win_clear || i_dp_cmd.emit_end) begin
            r_fill <= '0;
        end else if (i_dp_cmd.win_shift) begin
            r_fill <= r_fill - FW'(1);
        end else if (i_dp_cmd.win_push) begin
            r_fill <= r_fill + FW'(1);
        end
    end

    // Replacement memory with a registered read port.
    logic [EW-1:0]  r_rep_mem [MAX_REPLACEMENT];
    logic [EW-1:0]  r_rdata;
    logic [RCW-1:0] r_ridx;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.rep_wr && (32'(r_item_slot) < MAX_REPLACEMENT)) begin
            r_rep_mem[r_item_slot[RA-1:0]] <= {item_label_st, r_item_char};
        end
        r_rdata <= r_rep_mem[r_ridx[RA-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ridx <= '0;
        end else if (i_dp_cmd.repl_start) begin
            r_ridx <= '0;
        end else if (i_dp_cmd.emit_repl) begin
            r_ridx <= r_ridx + RCW'(1);
        end
    end

    // Output count and overflow tracking.
    logic [LIMIT_W-1:0] r_out_count;
    logic               r_overflow;
    logic [LIMIT_W:0]   repl_sum;
    logic               repl_fits;
    logic               at_limit;

    assign repl_sum  = {1'b0, r_out_count} + (LIMIT_W + 1)'(rn);
    assign repl_fits = repl_sum <= {1'b0, r_out_limit};
    assign at_limit  = r_out_count >= r_out_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_dp_cmd.emit_end) begin
            r_out_count <= '0;
            r_overflow  <= 1'b0;
        end else if (i_dp_cmd.emit_win && !r_overflow) begin
            if (at_limit) begin
                r_overflow <= 1'b1;
            end else begin
                r_out_count <= r_out_count + LIMIT_W'(1);
            end
        end else if (i_dp_cmd.repl_start && !r_overflow) begin
            if (!repl_fits) begin
                r_overflow <= 1'b1;
            end else begin
                r_out_count <= repl_sum[LIMIT_W-1:0];
            end
        end
    end

    // Output register.
    logic                  out_free;
    logic                  load_win;
    logic                  load_out;
    logic [LABEL_BITS-1:0] sel_label;
    logic [PLABEL_W-1:0]   sel_label_out;

    assign out_free = !o_out_valid || i_out_ready;
    assign load_win = i_dp_cmd.emit_win && !r_overflow && !at_limit;
    assign load_out = load_win || i_dp_cmd.emit_repl || i_dp_cmd.emit_end;
    assign sel_label = i_dp_cmd.emit_repl ? r_rdata[EW-1:CHAR_W] : r_win_lbl[0];

    for (genvar b = 0; b < PLABEL_W; b++) begin : g_lbl_out
        if (b < LABEL_BITS) begin : g_bit
            assign sel_label_out[b] = sel_label[b];
        end else begin : g_ext
            assign sel_label_out[b] = sel_label[LABEL_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.emit_end) begin
            o_atom_valid  <= 1'b0;
            o_out_char    <= '0;
            o_out_label   <= '0;
            o_end_of_text <= 1'b1;
            if (i_dp_cmd.end_undef) begin
                o_status <= ST_UNDEF;
            end else if (r_overflow) begin
                o_status <= ST_OVERFLOW;
            end else begin
                o_status <= ST_OK;
            end
        end else if (load_out) begin
            o_atom_valid  <= 1'b1;
            o_out_char    <= i_dp_cmd.emit_repl ? r_rdata[CHAR_W-1:0] : r_win_chr[0];
            o_out_label   <= sel_label_out;
            o_end_of_text <= 1'b0;
            o_status      <= ST_OK;
        end
    end

    // Status back to the controller.
    always_comb begin
        o_dp_stat.item_cmd     = r_item_cmd;
        o_dp_stat.item_last    = r_item_last;
        o_dp_stat.plen_zero    = (plen == '0);
        o_dp_stat.fill_ge_plen = (r_fill >= plen);
        o_dp_stat.fill_eq_plen = (r_fill == plen);
        o_dp_stat.fill_zero    = (r_fill == '0);
        o_dp_stat.match        = &entry_ok;
        o_dp_stat.repl_go      = !r_overflow && repl_fits && (rn != '0);
        o_dp_stat.repl_last    = (r_ridx == (rn - RCW'(1)));
        o_dp_stat.out_free     = out_free;
    end

    `GPRS_ASSERT_IMPLY(a_emit_needs_room, i_clk, i_rst_n,
        i_dp_cmd.emit_win || i_dp_cmd.emit_repl || i_dp_cmd.emit_end, out_free)
    `GPRS_ASSERT(a_end_clears, i_clk, i_rst_n,
        i_dp_cmd.emit_end |=> (r_fill == '0 && r_out_count == '0 && !r_overflow))
    `GPRS_ASSERT_IMPLY(a_push_has_room, i_clk, i_rst_n,
        i_dp_cmd.win_push, r_fill < plen)

endmodule

// ===== design/gprs_ctrl.sv =====
// Controller: sequences each input beat through decode, window update,
// compare, replacement burst, flush and end marker. Depends on gprs_pkg.
`include "greedy_pattern_replace_stream_top_macros.svh"

module gprs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gprs_pkg::t_dp_stat  i_dp_stat,
    output gprs_pkg::t_dp_cmd   o_dp_cmd
);
    import gprs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DROP,
        S_CHECK,
        S_REPL_RD,
        S_REPL_EMIT,
        S_FLUSH,
        S_END
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   n_in_ready;
    logic   r_undef;
    logic   n_undef;

    assign o_in_ready = r_in_ready;

    always_comb begin
        n_state  = r_state;
        n_undef  = r_undef;
        o_dp_cmd = '0;
        o_dp_cmd.end_undef = r_undef;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_dp_cmd.capture = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                unique case (i_dp_stat.item_cmd)
                    CMD_LOAD_PAT: o_dp_cmd.pat_wr = 1'b1;
                    CMD_LOAD_REP: o_dp_cmd.rep_wr = 1'b1;
                    CMD_TEXT: begin
                        if (i_dp_stat.plen_zero) begin
                            // Without a pattern the text is dropped.
                            o_dp_cmd.win_clear = 1'b1;
                            if (i_dp_stat.item_last) begin
                                n_undef = 1'b1;
                                n_state = S_END;
                            end
                        end else begin
                            n_state = S_DROP;
                        end
                    end
                    default: ;
                endcase
            end
            S_DROP: begin
                // Old atoms go unseen when the pattern got shorter mid-text.
                if (i_dp_stat.fill_ge_plen) begin
                    o_dp_cmd.win_shift = 1'b1;
                end else begin
                    o_dp_cmd.win_push = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_dp_stat.fill_eq_plen) begin
                    n_state = i_dp_stat.item_last ? S_FLUSH : S_IDLE;
                end else if (i_dp_stat.match) begin
                    o_dp_cmd.win_clear  = 1'b1;
                    o_dp_cmd.repl_start = 1'b1;
                    if (i_dp_stat.repl_go) begin
                        n_state = S_REPL_RD;
                    end else begin
                        n_state = i_dp_stat.item_last ? S_FLUSH : S_IDLE;
                    end
                end else if (i_dp_stat.out_free) begin
                    o_dp_cmd.emit_win  = 1'b1;
                    o_dp_cmd.win_shift = 1'b1;
                    n_state = i_dp_stat.item_last ? S_FLUSH : S_IDLE;
                end
            end
            S_REPL_RD: begin
                n_state = S_REPL_EMIT;
            end
            S_REPL_EMIT: begin
                if (i_dp_stat.out_free) begin
                    o_dp_cmd.emit_repl = 1'b1;
                    if (i_dp_stat.repl_last) begin
                        n_state = i_dp_stat.item_last ? S_FLUSH : S_IDLE;
                    end else begin
                        n_state = S_REPL_RD;
                    end
                end
            end
            S_FLUSH: begin
                if (i_dp_stat.fill_zero) begin
                    n_state = S_END;
                end else if (i_dp_stat.out_free) begin
                    o_dp_cmd.emit_win  = 1'b1;
                    o_dp_cmd.win_shift = 1'b1;
                end
            end
            S_END: begin
                if (i_dp_stat.out_free) begin
                    o_dp_cmd.emit_end = 1'b1;
                    n_undef = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_in_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
            r_undef    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
            r_undef    <= n_undef;
        end
    end

    `GPRS_ASSERT_IMPLY(a_ready_only_idle, i_clk, i_rst_n, r_in_ready, r_state == S_IDLE)
    `GPRS_ASSERT(a_end_returns_ready, i_clk, i_rst_n,
        ((r_state == S_END) && i_dp_stat.out_free) |=> r_in_ready)

endmodule

// ===== design/greedy_pattern_replace_stream_top.sv =====
// Top level of the greedy pattern replace stream block.
// Instantiates gprs_ctrl and gprs_dp; depends on gprs_pkg.

// Each accepted beat is worked one at a time by the controller. A load beat
// (pattern character or replacement atom) passes through the decode state,
// and so does a text beat while the pattern length is zero. Any other text
// beat also passes through the drop state, which first discards the oldest
// atoms after the pattern length was shortened, and the check state; each
// replacement atom then goes through the registered read of the replacement
// memory before it is placed in the output register. The final text beat
// flushes the remaining window atoms one by one, then closes the window and
// places the end marker; with an empty pattern it places only the end marker.
// Any stall on the output side stretches this sequence. The window compare
// against the pattern is combinational and done in parallel. No clearing
// pass runs after reset. Configuration writes are taken at any time on their
// own channel and must only arrive while the block is idle.
module greedy_pattern_replace_stream_top #(
    parameter int MAX_PATTERN     = 32,
    parameter int MAX_REPLACEMENT = 48,
    parameter int LABEL_BITS      = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [gprs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gprs_pkg::LIMIT_W-1:0]         i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [gprs_pkg::CMD_W-1:0]           i_cmd,
    input  logic [gprs_pkg::SLOT_W-1:0]          i_slot,
    input  logic [gprs_pkg::CHAR_W-1:0]          i_char_code,
    input  logic signed [gprs_pkg::PLABEL_W-1:0] i_label,
    input  logic                                 i_last,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_atom_valid,
    output logic [gprs_pkg::CHAR_W-1:0]          o_out_char,
    output logic signed [gprs_pkg::PLABEL_W-1:0] o_out_label,
    output logic                                 o_end_of_text,
    output logic [gprs_pkg::STATUS_W-1:0]        o_status
);
    import gprs_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Configuration registers are plain flops, so every write beat is taken.
    assign o_cfg_ready = 1'b1;

    gprs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_dp_stat  (dp_stat),
        .o_dp_cmd   (dp_cmd)
    );

    gprs_dp #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT),
        .LABEL_BITS      (LABEL_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (i_cmd),
        .i_slot        (i_slot),
        .i_char_code   (i_char_code),
        .i_label       (i_label),
        .i_last        (i_last),
        .i_dp_cmd      (dp_cmd),
        .o_dp_stat     (dp_stat),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_atom_valid  (o_atom_valid),
        .o_out_char    (o_out_char),
        .o_out_label   (o_out_label),
        .o_end_of_text (o_end_of_text),
        .o_status      (o_status)
    );

endmodule
